// ----- sv/sfce_pkg.sv -----
`default_nettype none
// ============================================================================
// sfce_pkg: shared definitions for the slicing floorplan cost evaluator
// Token kind codes, field widths and parameter defaults.
// ============================================================================
package sfce_pkg;

    // Field widths of the token and result words
    localparam int KIND_BITS  = 2;
    localparam int SIDE_BITS  = 8;
    localparam int OUT_BITS   = 16;
    localparam int COST_BITS  = 32;

    // Parameter defaults
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DIM_BITS_DEF    = 16;

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_SQUARE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PLUS   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TIMES  = 2'd2;

endpackage
`default_nettype wire

// ----- sv/sfce_if.sv -----
`default_nettype none
// ============================================================================
// sfce_tok_if / sfce_res_if: valid-ready channels of the evaluator
// One token word in, one result word out.
// ============================================================================
interface sfce_tok_if;
    logic                               valid;
    logic                               ready;
    logic [sfce_pkg::KIND_BITS-1:0]     kind;
    logic [sfce_pkg::SIDE_BITS-1:0]     side;
    logic                               last;

    modport source (output valid, kind, side, last, input ready);
    modport sink   (input valid, kind, side, last, output ready);
endinterface

interface sfce_res_if;
    logic                               valid;
    logic                               ready;
    logic [sfce_pkg::COST_BITS-1:0]     cost;
    logic [sfce_pkg::OUT_BITS-1:0]      box_width;
    logic [sfce_pkg::OUT_BITS-1:0]      box_height;
    logic                               malformed;

    modport source (output valid, cost, box_width, box_height, malformed, input ready);
    modport sink   (input valid, cost, box_width, box_height, malformed, output ready);
endinterface
`default_nettype wire

// ----- sv/slicing_floorplan_cost_evaluator.sv -----
`default_nettype none
// ============================================================================
// slicing_floorplan_cost_evaluator: postfix slicing floorplan evaluation
// Evaluates one token word per cycle on a box stack, unless a held result stalls
// the input, and reports the bounding box and its cost at the end of each expression.
// ============================================================================
// The block takes one token word per clock cycle. Squares push a box, plus
// stacks the top two boxes vertically (heights add, width is the larger), and
// times places them side by side (widths add, height is the larger); sums
// saturate at 2^DIM_BITS-1. The stack is a shift line of STACK_DEPTH entries
// whose top is always at entry 0, so a push or a combine finishes in the cycle
// the token is taken. On a token with last set, the result word appears on the
// next cycle with the box clipped to 16 bits and cost equal to the square of
// its larger side; malformed is set (and the other fields are zero) after any
// overflow, underflow or unused kind, or when the stack does not end with
// exactly one box. The stack and error flag then clear. The only stall comes
// from the result register: a token is refused only while a result is held
// and the sink is not ready.
module slicing_floorplan_cost_evaluator #(
    parameter int STACK_DEPTH = sfce_pkg::STACK_DEPTH_DEF,
    parameter int DIM_BITS    = sfce_pkg::DIM_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sfce_tok_if.sink    i_tok,
    sfce_res_if.source  o_res
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int OUT_BITS = sfce_pkg::OUT_BITS;

    // Stack storage: entry 0 is the top
    logic [DIM_BITS-1:0] r_w [STACK_DEPTH];
    logic [DIM_BITS-1:0] r_h [STACK_DEPTH];
    logic [DIM_BITS-1:0] n_w [STACK_DEPTH];
    logic [DIM_BITS-1:0] n_h [STACK_DEPTH];
    logic [DEPTH_W-1:0]  r_depth;
    logic [DEPTH_W-1:0]  n_depth;
    logic                r_err;
    logic                n_err;

    // Result register
    logic                          r_out_valid;
    logic [sfce_pkg::COST_BITS-1:0] r_cost;
    logic [OUT_BITS-1:0]           r_box_w;
    logic [OUT_BITS-1:0]           r_box_h;
    logic                          r_bad;

    logic                accept;
    logic [DIM_BITS-1:0] w_side;
    logic [DIM_BITS:0]   w_wsum;
    logic [DIM_BITS:0]   w_hsum;
    logic [DIM_BITS-1:0] w_wadd;
    logic [DIM_BITS-1:0] w_hadd;
    logic [DIM_BITS-1:0] w_wmax;
    logic [DIM_BITS-1:0] w_hmax;
    logic [31:0]         w_fw32;
    logic [31:0]         w_fh32;
    logic [OUT_BITS-1:0] w_fw;
    logic [OUT_BITS-1:0] w_fh;
    logic [OUT_BITS-1:0] w_fmax;
    logic [sfce_pkg::COST_BITS-1:0] w_cost;
    logic                w_good;

    // Handshake: take a word unless a held result is stalled
    assign i_tok.ready = !r_out_valid || o_res.ready;
    assign accept      = i_tok.valid && i_tok.ready;

    // Combine the top two boxes: saturating sums and maxima
    assign w_side = DIM_BITS'(i_tok.side);
    assign w_wsum = {1'b0, r_w[0]} + {1'b0, r_w[1]};
    assign w_hsum = {1'b0, r_h[0]} + {1'b0, r_h[1]};
    assign w_wadd = w_wsum[DIM_BITS] ? {DIM_BITS{1'b1}} : w_wsum[DIM_BITS-1:0];
    assign w_hadd = w_hsum[DIM_BITS] ? {DIM_BITS{1'b1}} : w_hsum[DIM_BITS-1:0];
    assign w_wmax = (r_w[0] >= r_w[1]) ? r_w[0] : r_w[1];
    assign w_hmax = (r_h[0] >= r_h[1]) ? r_h[0] : r_h[1];

    // Next stack state for the token at the input
    always_comb begin
        n_w     = r_w;
        n_h     = r_h;
        n_depth = r_depth;
        n_err   = r_err;
        case (i_tok.kind)
            sfce_pkg::KIND_SQUARE: begin
                if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                    n_err = 1'b1;
                end else begin
                    // push: shift down, new box on top
                    for (int i = 1; i < STACK_DEPTH; i++) begin
                        n_w[i] = r_w[i-1];
                        n_h[i] = r_h[i-1];
                    end
                    n_w[0]  = w_side;
                    n_h[0]  = w_side;
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end
            sfce_pkg::KIND_PLUS, sfce_pkg::KIND_TIMES: begin
                if (r_depth < DEPTH_W'(2)) begin
                    n_err = 1'b1;
                end else begin
                    // pop two, push the combined box: shift up under the top
                    for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                        n_w[i] = r_w[i+1];
                        n_h[i] = r_h[i+1];
                    end
                    if (i_tok.kind == sfce_pkg::KIND_PLUS) begin
                        n_w[0] = w_wmax;
                        n_h[0] = w_hadd;
                    end else begin
                        n_w[0] = w_wadd;
                        n_h[0] = w_hmax;
                    end
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    // Final box: clip to the output width, square the larger side
    assign w_good = !n_err && (n_depth == DEPTH_W'(1));
    assign w_fw32 = 32'(n_w[0]);
    assign w_fh32 = 32'(n_h[0]);
    assign w_fw   = (w_fw32 > 32'd65535) ? {OUT_BITS{1'b1}} : w_fw32[OUT_BITS-1:0];
    assign w_fh   = (w_fh32 > 32'd65535) ? {OUT_BITS{1'b1}} : w_fh32[OUT_BITS-1:0];
    assign w_fmax = (w_fw >= w_fh) ? w_fw : w_fh;
    assign w_cost = w_fmax * w_fmax;

    // Stack entries: advance on every accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w <= n_w;
            r_h <= n_h;
        end
    end

    // Depth and error flag: clear after the last token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= 1'b0;
        end else if (accept) begin
            if (i_tok.last) begin
                r_depth <= '0;
                r_err   <= 1'b0;
            end else begin
                r_depth <= n_depth;
                r_err   <= n_err;
            end
        end
    end

    // Result valid: set on the last token, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: hold until the next last token
    always_ff @(posedge i_clk) begin
        if (accept && i_tok.last) begin
            r_cost  <= w_good ? w_cost : '0;
            r_box_w <= w_good ? w_fw : '0;
            r_box_h <= w_good ? w_fh : '0;
            r_bad   <= !w_good;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cost       = r_cost;
    assign o_res.box_width  = r_box_w;
    assign o_res.box_height = r_box_h;
    assign o_res.malformed  = r_bad;

    // Checks
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_tok.last |=> r_depth == '0 && !r_err && o_res.valid)
        else $error("last token did not clear the stack or raise a result");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.malformed |->
            o_res.cost == '0 && o_res.box_width == '0 && o_res.box_height == '0)
        else $error("malformed result carries nonzero fields");

    a_cost_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.malformed && o_res.box_width >= o_res.box_height |->
            o_res.cost == o_res.box_width * o_res.box_width)
        else $error("cost is not the square of the larger side");

endmodule
`default_nettype wire
